// File: hw/rtl/mil_pkg.sv
// package: constants, codes and aes-128 round helpers for the milenage engine
`timescale 1ns / 1ps
package mil_pkg;

    typedef enum logic [1:0] {
        CMD_F1     = 2'd0,
        CMD_F1STAR = 2'd1,
        CMD_F2345  = 2'd2,
        CMD_F5STAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_KEY_HI    = 3'd0,
        CFG_KEY_LO    = 3'd1,
        CFG_OP_HI     = 3'd2,
        CFG_OP_LO     = 3'd3,
        CFG_OP_IS_OPC = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OPC,
        ST_TEMP,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_F4,
        ST_F5,
        ST_DONE
    } state_t;

    localparam int IN_W  = 200;
    localparam int OUT_W = 432;
    localparam logic [3:0] LAST_ROUND = 4'd10;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] x);
        xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // next round key, byte 0 in the top bits
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] n0, n1, n2, n3;
        t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        n0 = k[127:96] ^ t;
        n1 = k[95:64] ^ n0;
        n2 = k[63:32] ^ n1;
        n3 = k[31:0] ^ n2;
        key_step = {n0, n1, n2, n3};
    endfunction

    // sub bytes, shift rows and optional mix columns
    function automatic logic [127:0] round_core(input logic [127:0] s, input logic do_mix);
        logic [7:0] t [0:15];
        logic [7:0] a, b, d, e, all;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4 * c] = SBOX[s[127 - 8 * (i + 4 * ((c + i) & 3)) -: 8]];
            end
        end
        if (do_mix) begin
            for (int c = 0; c < 4; c++) begin
                a   = t[4 * c];
                b   = t[4 * c + 1];
                d   = t[4 * c + 2];
                e   = t[4 * c + 3];
                all = a ^ b ^ d ^ e;
                t[4 * c]     = a ^ all ^ xt(a ^ b);
                t[4 * c + 1] = b ^ all ^ xt(b ^ d);
                t[4 * c + 2] = d ^ all ^ xt(d ^ e);
                t[4 * c + 3] = e ^ all ^ xt(e ^ a);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8 * i -: 8] = t[i];
        end
        round_core = r;
    endfunction

endpackage

// File: hw/rtl/milenage_auth_functions.sv
// top level: milenage authentication engine on one iterative aes-128 round unit
`timescale 1ns / 1ps
// One command enters on the s_ side, one result leaves on the m_ side. All work runs through a
// single aes-128 round unit that does one round per cycle with the key schedule computed on the
// fly; one encryption is a load step followed by ten rounds. A command needs TEMP plus one output
// block (f1, f1*, f5*) or three (f2345), and one more encryption when OPc must be derived from OP
// after a configuration write; the result is then posted from ST_DONE. s_tready stays low from a
// command transfer until its result is posted, which waits while an earlier result still waits on
// m_tready. Configuration writes are always taken (cfg_ready high) and are meant for idle
// periods; any write to a listed register makes the next command re-derive OPc. Result fields
// that the command does not produce are zero. 128-bit values are big-endian, _hi first.
module milenage_auth_functions (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // command[1:0], rand_hi[65:2], rand_lo[129:66], sqn[177:130], amf[193:178], zero pad
    input  logic [mil_pkg::IN_W-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // mac[63:0], res[127:64], ak[175:128], ck_hi[239:176], ck_lo[303:240],
    // ik_hi[367:304], ik_lo[431:368]
    output logic [mil_pkg::OUT_W-1:0] m_tdata,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [2:0]               cfg_index,
    input  logic [63:0]              cfg_data
);
    import mil_pkg::*;

    state_t       state_reg, state_next;
    logic         run_reg, run_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [7:0]   rc_reg, rc_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] rk_reg, rk_next;

    logic [127:0] key_reg, op_reg;
    logic         op_is_opc_reg;
    logic         opc_ready_reg, opc_ready_next;
    logic [127:0] opc_reg, opc_next;
    logic [127:0] tmp_reg, tmp_next;

    cmd_t         cmd_reg, cmd_next;
    logic [127:0] rand_reg, rand_next;
    logic [47:0]  sqn_reg, sqn_next;
    logic [15:0]  amf_reg, amf_next;

    logic [63:0]  mac_reg, mac_next, res_reg, res_next;
    logic [47:0]  ak_reg, ak_next;
    logic [127:0] ck_reg, ck_next, ik_reg, ik_next;

    logic         out_valid_reg, out_valid_next;
    logic [431:0] out_data_reg, out_data_next;

    logic [127:0] blk_in, y, in1, rk_new, aes_out;
    logic         s_acc, cfg_acc, cfg_hit;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid & cfg_ready;
    assign cfg_hit   = cfg_acc & (cfg_index <= CFG_OP_IS_OPC);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // one aes round: key for this round and the state after it
    assign rk_new  = key_step(rk_reg, rc_reg);
    assign aes_out = round_core(st_reg, rnd_reg != LAST_ROUND) ^ rk_new;

    // block fed to the round unit in each phase
    always_comb
    begin
        y   = tmp_reg ^ opc_reg;
        in1 = {sqn_reg, amf_reg, sqn_reg, amf_reg} ^ opc_reg;
        unique case (state_reg)
            ST_OPC:  blk_in = op_reg;
            ST_TEMP: blk_in = rand_reg ^ opc_reg;
            ST_F1:   blk_in = {in1[63:0], in1[127:64]} ^ tmp_reg;
            ST_F2:   blk_in = y ^ 128'd1;
            ST_F3:   blk_in = {y[95:0], y[127:96]} ^ 128'd2;
            ST_F4:   blk_in = {y[63:0], y[127:64]} ^ 128'd4;
            ST_F5:   blk_in = {y[31:0], y[127:32]} ^ 128'd8;
            default: blk_in = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        run_next       = run_reg;
        rnd_next       = rnd_reg;
        rc_next        = rc_reg;
        st_next        = st_reg;
        rk_next        = rk_reg;
        opc_ready_next = opc_ready_reg;
        opc_next       = opc_reg;
        tmp_next       = tmp_reg;
        cmd_next       = cmd_reg;
        rand_next      = rand_reg;
        sqn_next       = sqn_reg;
        amf_next       = amf_reg;
        mac_next       = mac_reg;
        res_next       = res_reg;
        ak_next        = ak_reg;
        ck_next        = ck_reg;
        ik_next        = ik_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    cmd_next  = cmd_t'(s_tdata[1:0]);
                    rand_next = {s_tdata[65:2], s_tdata[129:66]};
                    sqn_next  = s_tdata[177:130];
                    amf_next  = s_tdata[193:178];
                    mac_next  = '0;
                    res_next  = '0;
                    ak_next   = '0;
                    ck_next   = '0;
                    ik_next   = '0;
                    run_next  = 1'b0;
                    if (opc_ready_reg)
                    begin
                        state_next = ST_TEMP;
                    end
                    else if (op_is_opc_reg)
                    begin
                        opc_next       = op_reg;
                        opc_ready_next = 1'b1;
                        state_next     = ST_TEMP;
                    end
                    else
                    begin
                        state_next = ST_OPC;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {ik_reg[63:0], ik_reg[127:64], ck_reg[63:0],
                                      ck_reg[127:64], ak_reg, res_reg, mac_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                if (!run_reg)
                begin
                    // initial add round key
                    st_next  = blk_in ^ key_reg;
                    rk_next  = key_reg;
                    rnd_next = 4'd1;
                    rc_next  = 8'h01;
                    run_next = 1'b1;
                end
                else
                begin
                    st_next  = aes_out;
                    rk_next  = rk_new;
                    rnd_next = rnd_reg + 4'd1;
                    rc_next  = xt(rc_reg);
                    if (rnd_reg == LAST_ROUND)
                    begin
                        run_next = 1'b0;
                        unique case (state_reg)
                            ST_OPC:
                            begin
                                opc_next       = aes_out ^ op_reg;
                                opc_ready_next = 1'b1;
                                state_next     = ST_TEMP;
                            end
                            ST_TEMP:
                            begin
                                tmp_next = aes_out;
                                unique case (cmd_reg)
                                    CMD_F1, CMD_F1STAR: state_next = ST_F1;
                                    CMD_F2345:          state_next = ST_F2;
                                    default:            state_next = ST_F5;
                                endcase
                            end
                            ST_F1:
                            begin
                                mac_next   = (cmd_reg == CMD_F1) ? (aes_out[127:64] ^ opc_reg[127:64])
                                                                 : (aes_out[63:0] ^ opc_reg[63:0]);
                                state_next = ST_DONE;
                            end
                            ST_F2:
                            begin
                                res_next   = aes_out[63:0] ^ opc_reg[63:0];
                                ak_next    = aes_out[127:80] ^ opc_reg[127:80];
                                state_next = ST_F3;
                            end
                            ST_F3:
                            begin
                                ck_next    = aes_out ^ opc_reg;
                                state_next = ST_F4;
                            end
                            ST_F4:
                            begin
                                ik_next    = aes_out ^ opc_reg;
                                state_next = ST_DONE;
                            end
                            default:
                            begin
                                ak_next    = aes_out[127:80] ^ opc_reg[127:80];
                                state_next = ST_DONE;
                            end
                        endcase
                    end
                end
            end
        endcase

        // any write to a listed register forces OPc to be taken again
        if (cfg_hit)
        begin
            opc_ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= 1'b0;
            rnd_reg       <= '0;
            rc_reg        <= '0;
            opc_ready_reg <= 1'b0;
            opc_reg       <= '0;
            key_reg       <= '0;
            op_reg        <= '0;
            op_is_opc_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            rnd_reg       <= rnd_next;
            rc_reg        <= rc_next;
            opc_ready_reg <= opc_ready_next;
            opc_reg       <= opc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_acc)
            begin
                priority case (cfg_index)
                    CFG_KEY_HI:    key_reg[127:64] <= cfg_data;
                    CFG_KEY_LO:    key_reg[63:0]   <= cfg_data;
                    CFG_OP_HI:     op_reg[127:64]  <= cfg_data;
                    CFG_OP_LO:     op_reg[63:0]    <= cfg_data;
                    CFG_OP_IS_OPC: op_is_opc_reg   <= cfg_data[0];
                    default:       ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        st_reg       <= st_next;
        rk_reg       <= rk_next;
        tmp_reg      <= tmp_next;
        cmd_reg      <= cmd_next;
        rand_reg     <= rand_next;
        sqn_reg      <= sqn_next;
        amf_reg      <= amf_next;
        mac_reg      <= mac_next;
        res_reg      <= res_next;
        ak_reg       <= ak_next;
        ck_reg       <= ck_next;
        ik_reg       <= ik_next;
        out_data_reg <= out_data_next;
    end

endmodule
